FILE: hw/rtl/hrdip_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrdip_pkg
// Shared beat types and item codes for the HID report descriptor item parser.
// ----------------------------------------------------------------------------
package hrdip_pkg;

    // One descriptor byte with its framing flags.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } byte_beat_t;

    // One parsed item together with the tracked parser context.
    typedef struct packed {
        logic        is_long;
        logic [1:0]  item_type;
        logic [7:0]  item_tag;
        logic [7:0]  data_size;
        logic [31:0] item_value;
        logic [3:0]  nest_depth;
        logic [31:0] usage_page;
        logic [31:0] usage_id;
        logic        truncated;
    } result_beat_t;

    // Prefix byte that opens a long item.
    localparam logic [7:0] LONG_PREFIX = 8'hFE;

    // Short item size code that stands for four data bytes.
    localparam logic [1:0] SIZE_CODE_FOUR = 2'd3;

    // Short item types.
    localparam logic [1:0] TYPE_MAIN   = 2'd0;
    localparam logic [1:0] TYPE_GLOBAL = 2'd1;
    localparam logic [1:0] TYPE_LOCAL  = 2'd2;

    // Short item tags of interest.
    localparam logic [3:0] TAG_COLLECTION     = 4'hA;
    localparam logic [3:0] TAG_END_COLLECTION = 4'hC;
    localparam logic [3:0] TAG_USAGE_PAGE     = 4'h0;
    localparam logic [3:0] TAG_USAGE          = 4'h0;

    // Hardware limit of the nesting depth counter.
    localparam int DEPTH_CEILING = 15;

endpackage

FILE: hw/rtl/hid_report_descriptor_item_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hid_report_descriptor_item_parser_core
// Splits a HID report descriptor byte stream into short and long items,
// tracking collection depth and the latest usage page and usage.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                      Payload
//  -------   ---------  -----------------------------  -------------------
//  byte      in         byte_valid / byte_ready        byte_data (byte_beat_t)
//  result    out        result_valid / result_ready    result_data (result_beat_t)
//
// One descriptor byte is taken per cycle; its item result, if any, shows up on
// the result register in the next cycle. The only loop is the parse state
// register, updated once per byte.
// A byte is taken whenever the result register is empty or being drained,
// so a stalled result blocks new bytes only while it is held.
// Reset returns the parser to expect a prefix byte with zero depth and latches.
//
module hid_report_descriptor_item_parser_core
    import hrdip_pkg::*;
#(
    parameter int MAX_DEPTH = 15
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         byte_valid,
    output logic         byte_ready,
    input  byte_beat_t   byte_data,
    output logic         result_valid,
    input  logic         result_ready,
    output result_beat_t result_data
);

    localparam int DepthLimit = (MAX_DEPTH < DEPTH_CEILING) ? MAX_DEPTH : DEPTH_CEILING;

    typedef enum logic [2:0] {
        PH_PREFIX,
        PH_SHORT_DATA,
        PH_LONG_SIZE,
        PH_LONG_TAG,
        PH_LONG_DATA
    } phase_t;

    phase_t       phase_reg,      phase_next, phase_cur;
    logic [7:0]   bytes_left_reg, bytes_left_next;
    logic [7:0]   prefix_reg,     prefix_next;
    logic [31:0]  value_reg,      value_next;
    logic [1:0]   pos_reg,        pos_next;
    logic [7:0]   long_size_reg,  long_size_next;
    logic [7:0]   long_tag_reg,   long_tag_next;
    logic [3:0]   depth_reg,      depth_next, depth_cur;
    logic [31:0]  page_reg,       page_next,  page_cur;
    logic [31:0]  usage_reg,      usage_next, usage_cur;

    logic         result_valid_reg;
    result_beat_t result_reg, result_next;

    logic         accept;
    logic         emit;
    logic         short_done;
    logic         long_done;
    logic [7:0]   b;
    logic [7:0]   long_dec;
    logic [1:0]   short_type;
    logic [3:0]   short_tag;
    logic [7:0]   short_size;

    assign b            = byte_data.data_byte;
    assign byte_ready   = !result_valid_reg || result_ready;
    assign accept       = byte_valid && byte_ready;
    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

    // A first byte starts from a clean parser and cleared context.
    always_comb
    begin
        phase_cur = byte_data.first_byte ? PH_PREFIX : phase_reg;
        depth_cur = byte_data.first_byte ? 4'd0 : depth_reg;
        page_cur  = byte_data.first_byte ? 32'd0 : page_reg;
        usage_cur = byte_data.first_byte ? 32'd0 : usage_reg;
    end

    assign long_dec = (bytes_left_reg != 8'd0) ? bytes_left_reg - 8'd1 : bytes_left_reg;

    // Parse step for one byte.
    always_comb
    begin
        phase_next      = phase_cur;
        bytes_left_next = bytes_left_reg;
        prefix_next     = prefix_reg;
        value_next      = value_reg;
        pos_next        = pos_reg;
        long_size_next  = long_size_reg;
        long_tag_next   = long_tag_reg;
        short_done      = 1'b0;
        long_done       = 1'b0;
        unique case (phase_cur)
            PH_PREFIX:
            begin
                if (b == LONG_PREFIX)
                begin
                    phase_next = PH_LONG_SIZE;
                end
                else
                begin
                    prefix_next     = b;
                    value_next      = 32'd0;
                    pos_next        = 2'd0;
                    bytes_left_next = (b[1:0] == SIZE_CODE_FOUR) ? 8'd4 : {6'd0, b[1:0]};
                    if (b[1:0] == 2'd0)
                    begin
                        short_done = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_SHORT_DATA;
                    end
                end
            end
            PH_SHORT_DATA:
            begin
                value_next      = value_reg | ({24'd0, b} << {pos_reg, 3'b000});
                pos_next        = pos_reg + 2'd1;
                bytes_left_next = bytes_left_reg - 8'd1;
                short_done      = (bytes_left_reg == 8'd1);
            end
            PH_LONG_SIZE:
            begin
                long_size_next = b;
                phase_next     = PH_LONG_TAG;
            end
            PH_LONG_TAG:
            begin
                long_tag_next   = b;
                bytes_left_next = long_size_reg;
                if (long_size_reg == 8'd0)
                begin
                    long_done = 1'b1;
                end
                else
                begin
                    phase_next = PH_LONG_DATA;
                end
            end
            PH_LONG_DATA:
            begin
                bytes_left_next = long_dec;
                long_done       = (long_dec == 8'd0);
            end
            default:
            begin
                phase_next = PH_PREFIX;
            end
        endcase
    end

    assign short_type = prefix_next[3:2];
    assign short_tag  = prefix_next[7:4];
    assign short_size = (prefix_next[1:0] == SIZE_CODE_FOUR) ? 8'd4 : {6'd0, prefix_next[1:0]};

    // Context update and result assembly.
    always_comb
    begin
        depth_next  = depth_cur;
        page_next   = page_cur;
        usage_next  = usage_cur;
        emit        = 1'b0;
        result_next = '0;
        if (short_done)
        begin
            emit                  = 1'b1;
            result_next.item_type = short_type;
            result_next.item_tag  = {4'd0, short_tag};
            result_next.data_size = short_size;
            result_next.item_value = value_next;
            if (short_type == TYPE_MAIN && short_tag == TAG_COLLECTION)
            begin
                if (depth_cur < 4'(DepthLimit))
                begin
                    depth_next = depth_cur + 4'd1;
                end
            end
            else if (short_type == TYPE_MAIN && short_tag == TAG_END_COLLECTION)
            begin
                if (depth_cur != 4'd0)
                begin
                    depth_next = depth_cur - 4'd1;
                end
            end
            else if (short_type == TYPE_GLOBAL && short_tag == TAG_USAGE_PAGE)
            begin
                page_next = value_next;
            end
            else if (short_type == TYPE_LOCAL && short_tag == TAG_USAGE)
            begin
                usage_next = value_next;
            end
        end
        else if (long_done)
        begin
            emit                 = 1'b1;
            result_next.is_long  = 1'b1;
            result_next.item_tag = long_tag_next;
            result_next.data_size = long_size_next;
        end
        else if (byte_data.last_byte)
        begin
            // The descriptor ended inside an item.
            emit                  = 1'b1;
            result_next.truncated = 1'b1;
            if (phase_next == PH_SHORT_DATA)
            begin
                result_next.item_type  = short_type;
                result_next.item_tag   = {4'd0, short_tag};
                result_next.data_size  = {6'd0, pos_next};
                result_next.item_value = value_next;
            end
            else if (phase_next == PH_LONG_DATA)
            begin
                result_next.is_long   = 1'b1;
                result_next.item_tag  = long_tag_next;
                result_next.data_size = long_size_next - bytes_left_next;
            end
            else
            begin
                result_next.is_long = 1'b1;
            end
        end
        result_next.nest_depth = depth_next;
        result_next.usage_page = page_next;
        result_next.usage_id   = usage_next;
    end

    // Parse state and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_PREFIX;
            bytes_left_reg   <= 8'd0;
            depth_reg        <= 4'd0;
            page_reg         <= 32'd0;
            usage_reg        <= 32'd0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg        <= (emit) ? PH_PREFIX : phase_next;
                bytes_left_reg   <= bytes_left_next;
                depth_reg        <= depth_next;
                page_reg         <= page_next;
                usage_reg        <= usage_next;
                result_valid_reg <= emit;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Item payload holders need no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prefix_reg    <= prefix_next;
            value_reg     <= value_next;
            pos_reg       <= pos_next;
            long_size_reg <= long_size_next;
            long_tag_reg  <= long_tag_next;
            if (emit)
            begin
                result_reg <= result_next;
            end
        end
    end

endmodule

FILE: hw/rtl/hrdip_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrdip_checker
// Port-level assertions for the HID report descriptor item parser.
// ----------------------------------------------------------------------------
module hrdip_checker
    import hrdip_pkg::*;
#(
    parameter int MAX_DEPTH = 15
)
(
    input logic         clk,
    input logic         rst_n,
    input logic         byte_valid,
    input logic         byte_ready,
    input byte_beat_t   byte_data,
    input logic         result_valid,
    input logic         result_ready,
    input result_beat_t result_data
);

    localparam int DepthLimit = (MAX_DEPTH < DEPTH_CEILING) ? MAX_DEPTH : DEPTH_CEILING;

    // A stalled result beat holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_data))
        else $error("stalled result beat changed");

    // An accepted last byte always closes an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && byte_ready && byte_data.last_byte |=> result_valid)
        else $error("last byte gave no result beat");

    // A first byte that is a data-less collection opens depth one on a clean context.
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && byte_ready && byte_data.first_byte && byte_data.data_byte == 8'hA0
        |=> result_valid && result_data.nest_depth == 4'd1
            && result_data.usage_page == 32'd0 && result_data.usage_id == 32'd0)
        else $error("first byte did not clear parse context");

    // Depth never passes its limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result_data.nest_depth <= 4'(DepthLimit))
        else $error("nesting depth above limit");

    // A truncated short item carries fewer than four data bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.truncated && !result_data.is_long
        |-> result_data.data_size < 8'd4)
        else $error("truncated short item too long");

endmodule

bind hid_report_descriptor_item_parser_core hrdip_checker #(
    .MAX_DEPTH(MAX_DEPTH)
) u_hrdip_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .byte_data    (byte_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data)
);
